FILE: hw/rtl/rbpb_pkg.sv
// Shared types, constants and step functions for the radial brush pixel blend unit.
package rbpb_pkg;

   localparam int COORD_W   = 13;
   localparam int PIX_W     = 12;
   localparam int RAD_W     = 6;
   localparam int CHAN_W    = 8;
   localparam int SUMSQ_W   = 13;
   localparam int SQ_VAL_W  = 32;
   localparam int SQ_REM_W  = 19;
   localparam int ROOT_W    = 16;
   localparam int QUOT_W    = 16;
   localparam int AMT_W     = 17;
   localparam int SPAN_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam int STAGES      = 11;
   localparam int SQ_FIRST    = 2;
   localparam int SQ_STGS     = 4;
   localparam int DIV_FIRST   = SQ_FIRST + SQ_STGS;
   localparam int DIV_STGS    = 4;
   localparam int STEPS_PER   = 4;
   localparam int BLEND_STAGE = DIV_FIRST + DIV_STGS;

   localparam logic [AMT_W-1:0]   AMT_ONE    = 17'h10000;
   localparam logic [COORD_W-1:0] SIZE_RESET = 13'd4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CANVAS_WIDTH  = 2'd0,
      CSR_CANVAS_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] centre_x;
      logic [COORD_W-1:0] centre_y;
      logic [RAD_W-1:0]   brush_radius;
      logic [CHAN_W-1:0]  brush_red;
      logic [CHAN_W-1:0]  brush_green;
      logic [CHAN_W-1:0]  brush_blue;
      logic [PIX_W-1:0]   pixel_x;
      logic [PIX_W-1:0]   pixel_y;
      logic [CHAN_W-1:0]  canvas_red;
      logic [CHAN_W-1:0]  canvas_green;
      logic [CHAN_W-1:0]  canvas_blue;
   } req_type;

   typedef struct packed {
      logic              painted;
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
   } rsp_type;

   typedef struct packed {
      logic [SQ_VAL_W-1:0] val;
      logic [SQ_REM_W-1:0] rem;
      logic [ROOT_W-1:0]   root;
   } sq_type;

   typedef struct packed {
      logic [QUOT_W-1:0] bits;
      logic [RAD_W-1:0]  rem;
      logic [QUOT_W-1:0] quot;
      logic              clamp;
   } dv_type;

   typedef struct packed {
      logic              painted;
      logic [CHAN_W-1:0] brush_red;
      logic [CHAN_W-1:0] brush_green;
      logic [CHAN_W-1:0] brush_blue;
      logic [CHAN_W-1:0] canvas_red;
      logic [CHAN_W-1:0] canvas_green;
      logic [CHAN_W-1:0] canvas_blue;
      logic [RAD_W-1:0]  radius;
      logic [RAD_W-1:0]  abs_x;
      logic [RAD_W-1:0]  abs_y;
      sq_type            sq;
      dv_type            dv;
   } work_type;

   // Clipped box test, upper bound exclusive.
   function automatic logic in_span(logic [PIX_W-1:0] p, logic [COORD_W-1:0] c,
                                    logic [RAD_W-1:0] r, logic [COORD_W-1:0] size);
      logic signed [SPAN_W-1:0] lo;
      logic signed [SPAN_W-1:0] hi;
      logic signed [SPAN_W-1:0] top;
      logic signed [SPAN_W-1:0] ps;
      lo  = $signed(SPAN_W'(c)) - $signed(SPAN_W'(r));
      hi  = $signed(SPAN_W'(c)) + $signed(SPAN_W'(r));
      top = $signed(SPAN_W'(size)) - $signed(SPAN_W'(1));
      ps  = $signed(SPAN_W'(p));
      if (lo < 0) lo = '0;
      if (hi > top) hi = top;
      return (ps >= lo) && (ps < hi);
   endfunction

   function automatic logic [RAD_W-1:0] abs_diff(logic [PIX_W-1:0] p, logic [COORD_W-1:0] c);
      logic signed [SPAN_W-1:0] d;
      d = $signed(SPAN_W'(p)) - $signed(SPAN_W'(c));
      if (d < 0) d = -d;
      return d[RAD_W-1:0];
   endfunction

   // One digit of the restoring square root, two radicand bits per step.
   function automatic sq_type sqrt_step(sq_type s);
      sq_type                o;
      logic [SQ_REM_W-1:0]   rem2;
      logic [SQ_REM_W-1:0]   trial;
      rem2  = {s.rem[SQ_REM_W-3:0], s.val[SQ_VAL_W-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      o.val = {s.val[SQ_VAL_W-3:0], 2'b00};
      if (rem2 >= trial) begin
         o.rem  = rem2 - trial;
         o.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         o.rem  = rem2;
         o.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return o;
   endfunction

   // One quotient bit of the restoring divide by the radius.
   function automatic dv_type div_step(dv_type d, logic [RAD_W-1:0] r);
      dv_type         o;
      logic [RAD_W:0] rem2;
      logic [RAD_W:0] diff;
      rem2    = {d.rem, d.bits[QUOT_W-1]};
      diff    = rem2 - {1'b0, r};
      o.bits  = {d.bits[QUOT_W-2:0], 1'b0};
      o.clamp = d.clamp;
      if (rem2 >= {1'b0, r}) begin
         o.rem  = diff[RAD_W-1:0];
         o.quot = {d.quot[QUOT_W-2:0], 1'b1};
      end else begin
         o.rem  = rem2[RAD_W-1:0];
         o.quot = {d.quot[QUOT_W-2:0], 1'b0};
      end
      return o;
   endfunction

   // stroke + (canvas - stroke) * amount, Q1.16 amount, result truncated.
   function automatic logic [CHAN_W-1:0] blend(logic [CHAN_W-1:0] s, logic [CHAN_W-1:0] c,
                                               logic [AMT_W-1:0] amount);
      logic signed [CHAN_W:0]   delta;
      logic signed [27:0]       delta_x;
      logic signed [27:0]       amount_x;
      logic signed [27:0]       prod;
      logic signed [27:0]       sum;
      delta    = $signed({1'b0, c}) - $signed({1'b0, s});
      delta_x  = 28'(delta);
      amount_x = 28'($signed({1'b0, amount}));
      prod     = delta_x * amount_x;
      sum      = $signed({4'b0, s, 16'b0}) + prod;
      return sum[23:16];
   endfunction

endpackage

FILE: hw/rtl/rbpb_datapath.sv
// Data registers of the blend pipeline: box test, squares, root, divide, blend.
module rbpb_datapath #(
   parameter int MAX_CANVAS = 4096,
   parameter int MAX_RADIUS = 63
) (
   input  logic                         clock,
   input  logic [rbpb_pkg::STAGES-1:0]  load,
   input  rbpb_pkg::req_type            req_data,
   input  logic [rbpb_pkg::COORD_W-1:0] canvas_width,
   input  logic [rbpb_pkg::COORD_W-1:0] canvas_height,
   output rbpb_pkg::rsp_type            rsp_data
);
   import rbpb_pkg::*;

   localparam logic [16:0] MAX_CANVAS_V = 17'(MAX_CANVAS);
   localparam logic [7:0]  MAX_RADIUS_V = 8'(MAX_RADIUS);

   work_type st_ff [BLEND_STAGE];
   work_type st_in [BLEND_STAGE];
   rsp_type  rsp_ff;
   rsp_type  rsp_in;

   logic [COORD_W-1:0] w_eff;
   logic [COORD_W-1:0] h_eff;
   logic [RAD_W-1:0]   r_eff;
   logic [SUMSQ_W-1:0] sumsq;
   logic [AMT_W-1:0]   amount;
   work_type           last;

   always_comb begin
      w_eff = ({4'b0, canvas_width} > MAX_CANVAS_V) ? COORD_W'(MAX_CANVAS) : canvas_width;
      h_eff = ({4'b0, canvas_height} > MAX_CANVAS_V) ? COORD_W'(MAX_CANVAS) : canvas_height;
      r_eff = ({2'b0, req_data.brush_radius} > MAX_RADIUS_V) ? RAD_W'(MAX_RADIUS)
                                                             : req_data.brush_radius;

      st_in[0]              = '0;
      st_in[0].painted      = (r_eff != '0)
                              && in_span(req_data.pixel_x, req_data.centre_x, r_eff, w_eff)
                              && in_span(req_data.pixel_y, req_data.centre_y, r_eff, h_eff);
      st_in[0].brush_red    = req_data.brush_red;
      st_in[0].brush_green  = req_data.brush_green;
      st_in[0].brush_blue   = req_data.brush_blue;
      st_in[0].canvas_red   = req_data.canvas_red;
      st_in[0].canvas_green = req_data.canvas_green;
      st_in[0].canvas_blue  = req_data.canvas_blue;
      st_in[0].radius       = r_eff;
      st_in[0].abs_x        = abs_diff(req_data.pixel_x, req_data.centre_x);
      st_in[0].abs_y        = abs_diff(req_data.pixel_y, req_data.centre_y);

      sumsq     = SUMSQ_W'(st_ff[0].abs_x) * SUMSQ_W'(st_ff[0].abs_x)
                  + SUMSQ_W'(st_ff[0].abs_y) * SUMSQ_W'(st_ff[0].abs_y);
      st_in[1]  = st_ff[0];
      st_in[1].sq.val  = {3'b0, sumsq, 16'b0};
      st_in[1].sq.rem  = '0;
      st_in[1].sq.root = '0;

      for (int i = SQ_FIRST; i < DIV_FIRST; i++) begin
         st_in[i] = st_ff[i-1];
         for (int k = 0; k < STEPS_PER; k++) begin
            st_in[i].sq = sqrt_step(st_in[i].sq);
         end
      end

      // divider setup: quotient saturates once root >= radius * 256
      st_in[DIV_FIRST-1].dv.clamp = st_in[DIV_FIRST-1].sq.root[15:8]
                                    >= {2'b0, st_in[DIV_FIRST-1].radius};
      st_in[DIV_FIRST-1].dv.rem   = st_in[DIV_FIRST-1].sq.root[13:8];
      st_in[DIV_FIRST-1].dv.bits  = {st_in[DIV_FIRST-1].sq.root[7:0], 8'b0};
      st_in[DIV_FIRST-1].dv.quot  = '0;

      for (int i = DIV_FIRST; i < BLEND_STAGE; i++) begin
         st_in[i] = st_ff[i-1];
         for (int k = 0; k < STEPS_PER; k++) begin
            st_in[i].dv = div_step(st_in[i].dv, st_in[i].radius);
         end
      end

      last   = st_ff[BLEND_STAGE-1];
      amount = last.dv.clamp ? AMT_ONE : {1'b0, last.dv.quot};
      rsp_in.painted = last.painted;
      if (last.painted) begin
         rsp_in.out_red   = blend(last.brush_red, last.canvas_red, amount);
         rsp_in.out_green = blend(last.brush_green, last.canvas_green, amount);
         rsp_in.out_blue  = blend(last.brush_blue, last.canvas_blue, amount);
      end else begin
         rsp_in.out_red   = last.canvas_red;
         rsp_in.out_green = last.canvas_green;
         rsp_in.out_blue  = last.canvas_blue;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BLEND_STAGE; i++) begin
         if (load[i]) st_ff[i] <= st_in[i];
      end
      if (load[BLEND_STAGE]) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hw/rtl/radial_brush_pixel_blend_unit.sv
// Top level: handshake control, canvas size registers and the blend pipeline.
// Throughput: one request per cycle; each stage holds while it is full and the one after it cannot take.
// The eleven register stages are box test, squares, four root stages, four divide stages, blend.
// Reset (synchronous) clears all stage valid bits and sets both canvas sizes to 4096.
module radial_brush_pixel_blend_unit #(
   parameter int MAX_CANVAS = 4096,
   parameter int MAX_RADIUS = 63
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rbpb_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rbpb_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rbpb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rbpb_pkg::COORD_W-1:0]   csr_wdata
);
   import rbpb_pkg::*;

   logic [STAGES-1:0]  valid_ff;
   logic [STAGES-1:0]  stage_ready;
   logic [COORD_W-1:0] width_ff;
   logic [COORD_W-1:0] height_ff;

   always_comb begin
      stage_ready[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[STAGES-1];
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else begin
         if (stage_ready[0]) valid_ff[0] <= req_valid;
         for (int i = 1; i < STAGES; i++) begin
            if (stage_ready[i]) valid_ff[i] <= valid_ff[i-1];
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_CANVAS_WIDTH:  width_ff  <= csr_wdata;
               CSR_CANVAS_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   rbpb_datapath #(
      .MAX_CANVAS(MAX_CANVAS),
      .MAX_RADIUS(MAX_RADIUS)
   ) u_datapath (
      .clock        (clock),
      .load         (stage_ready),
      .req_data     (req_data),
      .canvas_width (width_ff),
      .canvas_height(height_ff),
      .rsp_data     (rsp_data)
   );

endmodule

FILE: hw/rtl/rbpb_checker.sv
// Port-level checks of the blend unit and their bind.
module rbpb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input rbpb_pkg::req_type              req_data,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input rbpb_pkg::rsp_type              rsp_data
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("pending request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_no_stall_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request blocked while output drains");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request blocked without output backpressure");

endmodule

bind radial_brush_pixel_blend_unit rbpb_checker u_checker (.*);
